// ===== hdl/pcen_pkg.sv =====
// Shared types, constants and the square-root step function for the
// per-channel energy normalizer. No dependencies.
`default_nettype none

package pcen_pkg;

  // Field widths
  localparam int unsigned EW = 32;
  localparam int unsigned BW = 6;
  localparam int unsigned CW = 16;

  // Fixed-point constants
  localparam logic [CW-1:0] COEF_RST  = 16'd1638;   // b = 0.025 in Q0.16
  localparam logic [47:0]   EPS_Q32   = 48'd4295;   // 1e-6 in Q.32
  localparam logic [16:0]   GAIN_Q16  = 17'd64225;  // 0.98 in Q0.16
  localparam logic [31:0]   SQRT2_Q16 = 32'd92681;  // isqrt(2.0 in Q32.32)

  // Log fraction bits, and root bits resolved per square-root stage
  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned SQ_STEPS  = 4;
  localparam int unsigned SQ_STAGES = 32 / SQ_STEPS;

  // Item fields that ride along the pipeline
  typedef struct packed {
    logic [EW-1:0] e;
    logic [BW-1:0] band;
  } item_t;

  // Digit-by-digit square root state: radicand, partial remainder, root
  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sq_t;

  // Resolve SQ_STEPS root bits, two radicand bits each
  function automatic sq_t sqrt_steps(input sq_t s);
    sq_t         o;
    logic [35:0] remx;
    logic [35:0] trial;
    o = s;
    for (int k = 0; k < SQ_STEPS; k++) begin
      remx  = {o.rem, o.rad[63:62]};
      trial = {2'b00, o.root, 2'b01};
      if (remx >= trial) begin
        remx   = remx - trial;
        o.root = {o.root[30:0], 1'b1};
      end else begin
        o.root = {o.root[30:0], 1'b0};
      end
      o.rem = remx[33:0];
      o.rad = {o.rad[61:0], 2'b00};
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pcen_band_normalizer.sv =====
// Per-channel energy normalizer, top level: smoother store, log2, power,
// exp2 and square-root pipelines. Depends on pcen_pkg.
//
// Usage:
//   Input channel (in_*) takes one band energy (Q16.16), its band index and a
//   first-frame flag per request. Output channel (out_*) returns the PCEN value
//   (Q16.16) and the band index, one result per request, in order.
//   cfg_wr_en/cfg_wr_data write the smoothing weight b (Q0.16); write it only
//   while the pipeline is empty.
//   Throughput: one request per clock while the receiver does not stall. The
//   pipeline has 235 register stages. The depth is set by the 24 serial
//   squarings of the log2 unit and the 24 chained square roots of the exp2
//   unit (8 stages each, 4 root bits per stage), plus the final 8-stage root.
//   Stall: when the receiver stalls a valid result, the whole pipeline holds
//   and in_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset clears the valid bits and sets b to 0.025. The smoother store is
//   not cleared: each band must see a first-frame request before a blend.
//   Bands at or beyond NUM_BANDS bypass the store and behave as first frames.
`default_nettype none

module pcen_band_normalizer #(
  parameter int unsigned NUM_BANDS = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_wr_en,
  input  wire logic [pcen_pkg::CW-1:0] cfg_wr_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [pcen_pkg::EW-1:0] in_band_energy,
  input  wire logic [pcen_pkg::BW-1:0] in_band_index,
  input  wire logic                    in_first_frame,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [pcen_pkg::EW-1:0]      out_normalized_energy,
  output logic [pcen_pkg::BW-1:0]      out_band_out
);

  localparam int unsigned AW     = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int unsigned LG_ST  = pcen_pkg::FRAC_BITS;
  localparam int unsigned EXP_ST = pcen_pkg::FRAC_BITS * pcen_pkg::SQ_STAGES;
  localparam int unsigned FS_ST  = pcen_pkg::SQ_STAGES;
  // valid positions of a few stages
  localparam int unsigned P_LG0  = 4;
  localparam int unsigned NST    = 4 + (LG_ST + 1) + 1 + (EXP_ST + 1) + 2 + (FS_ST + 1) + 1;

  // Global advance: hold everything while the result is stalled
  logic adv;
  logic in_take;
  logic [NST-1:0] vld_r;

  assign adv       = !(vld_r[NST-1] && out_stall);
  assign in_stall  = vld_r[NST-1] && out_stall;
  assign in_take   = in_valid && adv;
  assign out_valid = vld_r[NST-1];

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_take};
    end
  end

  // Smoothing weight register
  logic [pcen_pkg::CW-1:0] coef_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= pcen_pkg::COEF_RST;
    end else if (cfg_wr_en) begin
      coef_r <= cfg_wr_data;
    end
  end

  // ---------------- Stage 0: capture request, read smoother ----------------
  logic [8:0]    in_band9;
  logic          in_inr;
  logic [AW-1:0] in_addr;

  assign in_band9 = {3'b000, in_band_index};
  assign in_inr   = in_band9 < 9'(NUM_BANDS);
  assign in_addr  = in_band9[AW-1:0];

  pcen_pkg::item_t s0_item_r;
  logic            s0_first_r;
  logic            s0_inr_r;
  logic [AW-1:0]   s0_addr_r;
  logic [31:0]     mem_q_r;
  logic            fwd_r;
  logic [31:0]     fwd_val_r;
  logic [31:0]     mem [NUM_BANDS];

  logic [31:0]        m_old;
  logic signed [32:0] m_diff;
  logic signed [49:0] m_prod;
  logic signed [50:0] m_acc;
  logic [31:0]        m_new;
  logic               s0_wr;

  // Blend: (65536-b)M + bE = 65536M + b(E-M)
  assign m_old  = fwd_r ? fwd_val_r : mem_q_r;
  assign m_diff = $signed({1'b0, s0_item_r.e}) - $signed({1'b0, m_old});
  assign m_prod = $signed({1'b0, coef_r}) * m_diff;
  assign m_acc  = $signed({3'b000, m_old, 16'h0000}) + 51'(m_prod) + 51'sd32768;
  assign m_new  = (!s0_inr_r || s0_first_r) ? s0_item_r.e : m_acc[47:16];
  assign s0_wr  = adv && vld_r[0] && s0_inr_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_item_r.e    <= in_band_energy;
      s0_item_r.band <= in_band_index;
      s0_first_r     <= in_first_frame;
      s0_inr_r       <= in_inr;
      s0_addr_r      <= in_addr;
      // forward the value being written when the next request hits the same band
      fwd_r          <= vld_r[0] && s0_inr_r && in_inr && (s0_addr_r == in_addr);
      fwd_val_r      <= m_new;
    end
  end

  // Smoother store: read-first, one read and one write port
  always_ff @(posedge clk) begin
    if (in_take && in_inr) begin
      mem_q_r <= mem[in_addr];
    end
    if (s0_wr) begin
      mem[s0_addr_r] <= m_new;
    end
  end

  // ---------------- Stages 1..4: log argument and normalization ----------------
  pcen_pkg::item_t s1_item_r, s2_item_r, s3_item_r;
  logic [31:0]     s1_m_r;
  logic [47:0]     s2_x_r, s3_x_r;
  logic [5:0]      s3_n_r;
  logic [5:0]      lzd_n;
  logic [78:0]     norm_wide;

  // Locate top set bit of x
  always_comb begin
    lzd_n = '0;
    for (int i = 0; i < 48; i++) begin
      if (s2_x_r[i]) begin
        lzd_n = 6'(i);
      end
    end
  end

  assign norm_wide = {s3_x_r, 31'b0} >> s3_n_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r <= s0_item_r;
      s1_m_r    <= m_new;
      s2_item_r <= s1_item_r;
      s2_x_r    <= {s1_m_r, 16'h0000} + pcen_pkg::EPS_Q32;
      s3_item_r <= s2_item_r;
      s3_x_r    <= s2_x_r;
      s3_n_r    <= lzd_n;
    end
  end

  // ---------------- Log2 fraction: one squaring per stage ----------------
  pcen_pkg::item_t          lg_it_r [LG_ST+1];
  logic [31:0]              lg_m_r  [LG_ST+1];
  logic [LG_ST-1:0]         lg_f_r  [LG_ST+1];
  logic [5:0]               lg_n_r  [LG_ST+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      lg_it_r[0] <= s3_item_r;
      lg_m_r[0]  <= norm_wide[31:0];
      lg_f_r[0]  <= '0;
      lg_n_r[0]  <= s3_n_r;
    end
  end

  for (genvar j = 0; j < LG_ST; j++) begin : g_log
    logic [63:0] sq;
    logic        bitv;
    assign sq   = {32'b0, lg_m_r[j]} * {32'b0, lg_m_r[j]};
    assign bitv = sq[63];
    always_ff @(posedge clk) begin
      if (adv) begin
        lg_it_r[j+1] <= lg_it_r[j];
        lg_n_r[j+1]  <= lg_n_r[j];
        lg_f_r[j+1]  <= {lg_f_r[j][LG_ST-2:0], bitv};
        lg_m_r[j+1]  <= bitv ? sq[63:32] : sq[62:31];
      end
    end
  end

  // ---------------- Power: p = -0.98 * log2 ----------------
  logic signed [31:0] lval;
  logic signed [32:0] negl;
  logic signed [50:0] t_nxt;
  pcen_pkg::item_t    t_it_r;
  logic signed [50:0] t_r;
  logic signed [50:0] t_rnd;
  logic signed [50:0] p_val;

  assign lval  = $signed({2'b00, lg_n_r[LG_ST], 24'h000000}) - $signed(32'h2000_0000)
               + $signed({8'h00, lg_f_r[LG_ST]});
  assign negl  = -$signed({lval[31], lval});
  assign t_nxt = negl * $signed({1'b0, pcen_pkg::GAIN_Q16});
  assign t_rnd = t_r + 51'sd32768;
  assign p_val = t_rnd >>> 16;

  always_ff @(posedge clk) begin
    if (adv) begin
      t_it_r <= lg_it_r[LG_ST];
      t_r    <= t_nxt;
    end
  end

  // ---------------- Exp2 of the fraction: chained square roots ----------------
  pcen_pkg::item_t     ex_it_r [EXP_ST+1];
  logic signed [7:0]   ex_ip_r [EXP_ST+1];
  logic [LG_ST-1:0]    ex_f_r  [EXP_ST+1];
  pcen_pkg::sq_t       ex_sq_r [1:EXP_ST];

  always_ff @(posedge clk) begin
    if (adv) begin
      ex_it_r[0] <= t_it_r;
      ex_ip_r[0] <= p_val[31:24];
      ex_f_r[0]  <= p_val[23:0];
    end
  end

  for (genvar j = 1; j <= EXP_ST; j++) begin : g_exp
    localparam int unsigned I = (j - 1) / pcen_pkg::SQ_STAGES;
    localparam int unsigned K = (j - 1) % pcen_pkg::SQ_STAGES;
    pcen_pkg::sq_t sq_in;
    if (K == 0) begin : g_load
      logic [32:0] y_prev;
      logic [32:0] y2;
      if (I == 0) begin : g_one
        assign y_prev = 33'h0_4000_0000;
      end else begin : g_chain
        assign y_prev = {1'b0, ex_sq_r[j-1].root};
      end
      // double y when this fraction bit is set, then take the root
      assign y2         = ex_f_r[j-1][I] ? {y_prev[31:0], 1'b0} : y_prev;
      assign sq_in.rad  = {1'b0, y2, 30'b0};
      assign sq_in.rem  = '0;
      assign sq_in.root = '0;
    end else begin : g_cont
      assign sq_in = ex_sq_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        ex_it_r[j] <= ex_it_r[j-1];
        ex_ip_r[j] <= ex_ip_r[j-1];
        ex_f_r[j]  <= ex_f_r[j-1];
        ex_sq_r[j] <= pcen_pkg::sqrt_steps(sq_in);
      end
    end
  end

  // ---------------- Gain, scale and offset ----------------
  pcen_pkg::item_t   z_it_r, w_it_r;
  logic [63:0]       z_r, w_r;
  logic signed [7:0] z_ip_r;
  logic signed [8:0] sh_s;
  logic signed [8:0] sh_ns;
  logic [127:0]      sh_left;
  logic [63:0]       w_nxt;
  logic [64:0]       v_sum;

  assign sh_s    = $signed({z_ip_r[7], z_ip_r}) - 9'sd14;
  assign sh_ns   = -sh_s;
  assign sh_left = {64'b0, z_r} << sh_s[5:0];

  // Scale by 2^(ip-14): saturate on left overflow, floor on right
  always_comb begin
    if (!sh_s[8]) begin
      if (sh_s[7:6] != 2'b00 || sh_left[127:64] != 64'b0) begin
        w_nxt = '1;
      end else begin
        w_nxt = sh_left[63:0];
      end
    end else begin
      if (sh_ns[8:6] != 3'b000) begin
        w_nxt = '0;
      end else begin
        w_nxt = z_r >> sh_ns[5:0];
      end
    end
  end

  assign v_sum = {1'b0, w_r} + 65'h0_0000_0002_0000_0000;

  // ---------------- Final square root ----------------
  pcen_pkg::item_t fs_it_r [FS_ST+1];
  pcen_pkg::sq_t   fs_sq_r [FS_ST+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      z_it_r          <= ex_it_r[EXP_ST];
      z_ip_r          <= ex_ip_r[EXP_ST];
      z_r             <= {32'b0, ex_it_r[EXP_ST].e} * {32'b0, ex_sq_r[EXP_ST].root};
      w_it_r          <= z_it_r;
      w_r             <= w_nxt;
      fs_it_r[0]      <= w_it_r;
      fs_sq_r[0].rad  <= v_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : v_sum[63:0];
      fs_sq_r[0].rem  <= '0;
      fs_sq_r[0].root <= '0;
    end
  end

  for (genvar j = 1; j <= FS_ST; j++) begin : g_fs
    always_ff @(posedge clk) begin
      if (adv) begin
        fs_it_r[j] <= fs_it_r[j-1];
        fs_sq_r[j] <= pcen_pkg::sqrt_steps(fs_sq_r[j-1]);
      end
    end
  end

  // Output register: subtract sqrt(2)
  logic [31:0]             out_ne_r;
  logic [pcen_pkg::BW-1:0] out_band_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      out_ne_r   <= fs_sq_r[FS_ST].root - pcen_pkg::SQRT2_Q16;
      out_band_r <= fs_it_r[FS_ST].band;
    end
  end

  assign out_normalized_energy = out_ne_r;
  assign out_band_out          = out_band_r;

`ifndef SYNTHESIS
  // log mantissa is always normalized to [1,2)
  a_mant_norm: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[P_LG0] |-> lg_m_r[0][31])
    else $error("log mantissa not normalized");

  // final root never drops below sqrt(2)
  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NST-2] |-> (fs_sq_r[FS_ST].root >= pcen_pkg::SQRT2_Q16))
    else $error("final root below sqrt(2)");

  // back-to-back hit on the same band must take the forwarded value
  a_fwd_set: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_inr && vld_r[0] && s0_inr_r && (s0_addr_r == in_addr)) |=> fwd_r)
    else $error("missing smoother forward");

  // a result about to leave the last root stage reaches the output
  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vld_r[NST-2]) |=> out_valid)
    else $error("result lost before output");

  // input is held off only by a stalled result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output stall");
`endif

endmodule

`default_nettype wire
